// ===== src/bcent_pkg.sv =====
// Shared widths and defaults for the blob centroid tracker.
// Used by bcent_isqrt and blob_centroid_tracker_unit; depends on nothing.
package bcent_pkg;

   localparam int X_W           = 10;
   localparam int Y_W           = 9;
   localparam int MD_W          = 10;
   localparam int TRACK_W       = 16;
   localparam int REQ_DATA_W    = 24;
   localparam int REQ_USER_W    = 1;
   localparam int RSP_USER_W    = 2;
   localparam int D2_W          = 20;
   localparam int ROOT_W        = D2_W / 2;
   localparam int MAX_BLOBS_DEF = 32;
   localparam int ID_BITS_DEF   = 16;

   localparam logic [MD_W-1:0] MD_RESET = MD_W'(30);

endpackage

// ===== src/bcent_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on bcent_pkg for D2_W and ROOT_W.
module bcent_isqrt
   import bcent_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [D2_W-1:0]   value,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [D2_W-1:0]  rem_ff, rem_in;
   logic [D2_W-1:0]  res_ff, res_in;
   logic [D2_W-1:0]  bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D2_W:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      if (start) begin
         rem_in  = value;
         res_in  = '0;
         bit_in  = D2_W'(1) << (D2_W - 2);
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[D2_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

// ===== src/blob_centroid_tracker_unit.sv =====
// Top level of the blob centroid tracker: sequencer, two-bank centroid memory, output word.
// Depends on bcent_pkg and bcent_isqrt.
//
//  channel  direction  words
//  req_     in         one blob centroid or a frame end per word
//  rsp_     out        one track ID per word that carried a blob
//  csr_     in         match distance write
//
// A word without a blob is handled in the idle state and needs no search. For a blob word, each entry
// kept from the previous frame is read, squared through one shared multiplier and rooted in the
// bit-serial square root unit.
// A new word is taken while the last result still waits on rsp_tready.
// Reset clears the blob and ID counters and the bank select and sets the match distance to 30.
module blob_centroid_tracker_unit
   import bcent_pkg::*;
#(
   parameter int MAX_BLOBS = MAX_BLOBS_DEF,
   parameter int ID_BITS   = ID_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // blob_x, blob_y
   input  logic [REQ_USER_W-1:0] req_tuser,   // has_blob
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TRACK_W-1:0]    rsp_tdata,   // track_id
   output logic [RSP_USER_W-1:0] rsp_tuser,   // is_new, dropped
   input  logic                  csr_wen,
   input  logic [MD_W-1:0]       csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOBS + 1);
   localparam int IDX_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
   localparam int AW    = IDX_W + 1;
   localparam int ENT_W = ID_BITS + Y_W + X_W;
   localparam int CMP_W = (MD_W > ROOT_W) ? MD_W : ROOT_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_FETCH  = 8'b00000010,
      S_DIFF   = 8'b00000100,
      S_SQX    = 8'b00001000,
      S_SQY    = 8'b00010000,
      S_ROOT   = 8'b00100000,
      S_DECIDE = 8'b01000000,
      S_FINISH = 8'b10000000
   } state_type;

   state_type          state_ff, state_in;
   logic               bank_ff, bank_in;
   logic [CNT_W-1:0]   prev_cnt_ff, prev_cnt_in;
   logic [CNT_W-1:0]   cur_cnt_ff, cur_cnt_in;
   logic [ID_BITS-1:0] id_ctr_ff, id_ctr_in;
   logic [MD_W-1:0]    md_ff;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [X_W-1:0]     bx_ff, bx_in;
   logic [Y_W-1:0]     by_ff, by_in;
   logic               fend_ff, fend_in;
   logic [X_W-1:0]     dx_ff, dx_in;
   logic [X_W-1:0]     dy_ff, dy_in;
   logic [D2_W-1:0]    d2_ff, d2_in;
   logic [ID_BITS-1:0] ent_id_ff, ent_id_in;
   logic [ROOT_W-1:0]  best_ff, best_in;
   logic [ID_BITS-1:0] best_id_ff, best_id_in;
   logic [ID_BITS-1:0] res_id_ff, res_id_in;
   logic               res_new_ff, res_new_in;
   logic               res_drop_ff, res_drop_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic [ENT_W-1:0]   mem [2**AW];
   logic [ENT_W-1:0]   rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [ENT_W-1:0]   mem_wdata;

   logic [X_W-1:0]     mul_a;
   logic [2*X_W-1:0]   product;
   logic [D2_W-1:0]    sq_sum;
   logic               root_start;
   logic               root_done;
   logic [ROOT_W-1:0]  root;
   logic [X_W-1:0]     px;
   logic [Y_W-1:0]     py;
   logic               fresh;
   logic               drop;
   logic [ID_BITS-1:0] id_next;
   logic [ID_BITS+TRACK_W-1:0] id_wide;

   bcent_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (sq_sum),
      .done  (root_done),
      .root  (root)
   );

   assign px      = rd_data_ff[X_W-1:0];
   assign py      = rd_data_ff[X_W+Y_W-1:X_W];
   assign rd_addr = {~bank_ff, k_ff[IDX_W-1:0]};
   assign mul_a   = (state_ff == S_SQX) ? dx_ff : dy_ff;
   assign product = mul_a * mul_a;
   assign sq_sum  = d2_ff + D2_W'(product);
   assign root_start = (state_ff == S_SQY);
   assign fresh   = (prev_cnt_ff == '0) || (CMP_W'(best_ff) > CMP_W'(md_ff));
   assign drop    = (cur_cnt_ff >= CNT_W'(MAX_BLOBS));
   assign id_next = id_ctr_ff + ID_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      prev_cnt_in  = prev_cnt_ff;
      cur_cnt_in   = cur_cnt_ff;
      id_ctr_in    = id_ctr_ff;
      k_in         = k_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      fend_in      = fend_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      d2_in        = d2_ff;
      ent_id_in    = ent_id_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      res_id_in    = res_id_ff;
      res_new_in   = res_new_ff;
      res_drop_in  = res_drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      mem_waddr    = {bank_ff, cur_cnt_ff[IDX_W-1:0]};
      mem_wdata    = {res_id_in, by_ff, bx_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               bx_in   = req_tdata[X_W-1:0];
               by_in   = req_tdata[X_W+Y_W-1:X_W];
               fend_in = req_tlast;
               k_in    = '0;
               if (req_tuser[0]) begin
                  state_in = (prev_cnt_ff == '0) ? S_DECIDE : S_FETCH;
               end else if (req_tlast) begin
                  prev_cnt_in = cur_cnt_ff;
                  cur_cnt_in  = '0;
                  bank_in     = ~bank_ff;
               end
            end
         end
         S_FETCH: begin
            state_in = S_DIFF;
         end
         S_DIFF: begin
            dx_in     = (bx_ff >= px) ? bx_ff - px : px - bx_ff;
            dy_in     = X_W'((by_ff >= py) ? by_ff - py : py - by_ff);
            ent_id_in = rd_data_ff[ENT_W-1:X_W+Y_W];
            state_in  = S_SQX;
         end
         S_SQX: begin
            d2_in    = D2_W'(product);
            state_in = S_SQY;
         end
         S_SQY: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (root_done) begin
               if (k_ff == '0 || root <= best_ff) begin
                  best_in    = root;
                  best_id_in = ent_id_ff;
               end
               k_in = k_ff + CNT_W'(1);
               if (k_ff + CNT_W'(1) >= prev_cnt_ff) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_DECIDE: begin
            res_new_in  = fresh;
            res_drop_in = drop;
            if (fresh) begin
               id_ctr_in = id_next;
               res_id_in = id_next;
            end else begin
               res_id_in = best_id_ff;
            end
            mem_wdata = {res_id_in, by_ff, bx_ff};
            if (!drop) begin
               mem_we     = 1'b1;
               cur_cnt_in = cur_cnt_ff + CNT_W'(1);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_user_in  = {res_drop_ff, res_new_ff};
               if (fend_ff) begin
                  prev_cnt_in = cur_cnt_ff;
                  cur_cnt_in  = '0;
                  bank_in     = ~bank_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      fend_ff     <= fend_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      d2_ff       <= d2_in;
      ent_id_ff   <= ent_id_in;
      best_ff     <= best_in;
      best_id_ff  <= best_id_in;
      res_id_ff   <= res_id_in;
      res_new_ff  <= res_new_in;
      res_drop_ff <= res_drop_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_user_ff <= rsp_user_in;
      k_ff        <= k_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         bank_ff      <= 1'b0;
         prev_cnt_ff  <= '0;
         cur_cnt_ff   <= '0;
         id_ctr_ff    <= '0;
         md_ff        <= MD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         prev_cnt_ff  <= prev_cnt_in;
         cur_cnt_ff   <= cur_cnt_in;
         id_ctr_ff    <= id_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            md_ff <= csr_wdata;
         end
      end
   end

   assign id_wide    = {{TRACK_W{1'b0}}, rsp_id_ff};
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = id_wide[TRACK_W-1:0];
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== test/bcent_track_checker.sv =====
// Checker for blob_centroid_tracker_unit: watches the req, rsp and csr ports, tracks blob IDs
// across frames and compares every result word with the predicted one.
// Depends on bcent_pkg.
module bcent_track_checker
   import bcent_pkg::*;
#(
   parameter int MAX_BLOBS = MAX_BLOBS_DEF,
   parameter int ID_BITS   = ID_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // blob_x, blob_y
   input  logic [REQ_USER_W-1:0] req_tuser,   // has_blob
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [TRACK_W-1:0]    rsp_tdata,   // track_id
   input  logic [RSP_USER_W-1:0] rsp_tuser,   // is_new, dropped
   input  logic                  csr_wen,
   input  logic [MD_W-1:0]       csr_wdata,
   output int                    fail_count,
   output int                    backlog,
   output int                    results_seen,
   output int                    fresh_seen,
   output int                    drops_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [TRACK_W-1:0] track_id;
      logic               is_new;
      logic               dropped;
   } track_result_type;

   track_result_type   pending_tracks[$];
   logic [MD_W-1:0]    match_dist;
   logic [X_W-1:0]     bank_x [2][MAX_BLOBS];
   logic [Y_W-1:0]     bank_y [2][MAX_BLOBS];
   logic [ID_BITS-1:0] bank_id [2][MAX_BLOBS];
   logic               write_bank;
   int                 prev_fill;
   int                 cur_fill;
   logic [ID_BITS-1:0] last_id;
   int                 fails;
   int                 n_results;
   int                 n_fresh;
   int                 n_drops;

   // Builds the root one bit at a time from the top.
   function automatic int unsigned root_floor(input int unsigned v);
      int unsigned r;
      int unsigned t;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
         t = r | (32'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic void track_blob(input logic has, input logic [X_W-1:0] bx,
                                      input logic [Y_W-1:0] by, input logic last);
      int            dx;
      int            dy;
      int unsigned   span;
      int unsigned   best_dist;
      logic          hit;
      logic          fresh;
      logic          rd_bank;
      logic [ID_BITS-1:0] best_id;
      logic [ID_BITS-1:0] id;
      track_result_type want;
      if (has) begin
         rd_bank   = !write_bank;
         hit       = 1'b0;
         best_dist = 0;
         best_id   = '0;
         for (int k = 0; k < prev_fill; k++) begin
            dx = int'(bx) - int'(bank_x[rd_bank][k]);
            dy = int'(by) - int'(bank_y[rd_bank][k]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            span = root_floor(dx * dx + dy * dy);
            // Ties go to the entry stored later in the previous frame.
            if (!hit || span <= best_dist) begin
               hit       = 1'b1;
               best_dist = span;
               best_id   = bank_id[rd_bank][k];
            end
         end
         fresh = !hit || best_dist > match_dist;
         if (fresh) begin
            last_id = last_id + 1'b1;
            id      = last_id;
         end else begin
            id = best_id;
         end
         want.track_id = TRACK_W'(id);
         want.is_new   = fresh;
         want.dropped  = (cur_fill >= MAX_BLOBS);
         if (!want.dropped) begin
            bank_x[write_bank][cur_fill]  = bx;
            bank_y[write_bank][cur_fill]  = by;
            bank_id[write_bank][cur_fill] = id;
            cur_fill++;
         end
         pending_tracks = {pending_tracks, want};
      end
      if (last) begin
         prev_fill  = cur_fill;
         cur_fill   = 0;
         write_bank = !write_bank;
      end
   endfunction

   always @(posedge clock) begin
      track_result_type want;
      track_result_type got;
      if (reset) begin
         match_dist = MD_RESET;
         write_bank = 1'b0;
         prev_fill  = 0;
         cur_fill   = 0;
         last_id    = '0;
         pending_tracks.delete();
      end else begin
         if (csr_wen) match_dist = csr_wdata;
         if (req_tvalid && req_tready) begin
            track_blob(req_tuser[0], req_tdata[X_W-1:0], req_tdata[X_W+Y_W-1:X_W], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.track_id = rsp_tdata;
            got.is_new   = rsp_tuser[0];
            got.dropped  = rsp_tuser[1];
            n_results++;
            if (pending_tracks.size() == 0) begin
               fails++;
               if (fails <= 10) begin
                  $display("%0t: unexpected result word id %0d new %0b drop %0b", $realtime,
                           got.track_id, got.is_new, got.dropped);
               end
            end else begin
               want = pending_tracks.pop_front();
               if (want.is_new) n_fresh++;
               if (want.dropped) n_drops++;
               if (got.track_id != want.track_id || got.is_new != want.is_new ||
                   got.dropped != want.dropped) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: result %0d expected id %0d new %0b drop %0b, got id %0d new %0b drop %0b",
                              $realtime, n_results, want.track_id, want.is_new, want.dropped,
                              got.track_id, got.is_new, got.dropped);
                  end
               end
            end
         end
      end
      fail_count   <= fails;
      backlog      <= pending_tracks.size();
      results_seen <= n_results;
      fresh_seen   <= n_fresh;
      drops_seen   <= n_drops;
   end

   initial begin
      fails     = 0;
      n_results = 0;
      n_fresh   = 0;
      n_drops   = 0;
   end

endmodule

// ===== test/tb_blob_centroid_tracker_unit.sv =====
// Testbench top for blob_centroid_tracker_unit: clock, reset, frame stimulus with random stalls.
// Depends on bcent_pkg, blob_centroid_tracker_unit and bcent_track_checker.
module tb_blob_centroid_tracker_unit;
   import bcent_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_CAP = MAX_BLOBS_DEF;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TRACK_W-1:0]    rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wen    = 1'b0;
   logic [MD_W-1:0]       csr_wdata  = '0;

   int   fail_count;
   int   backlog;
   int   results_seen;
   int   fresh_seen;
   int   drops_seen;

   logic calm          = 1'b0;
   logic long_hold_arm = 1'b0;
   logic hold_used     = 1'b0;
   int   hold_left     = 0;
   int   words_sent    = 0;
   int   settings_used = 0;
   int   seen_x[$];
   int   seen_y[$];

   blob_centroid_tracker_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   bcent_track_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .backlog      (backlog),
      .results_seen (results_seen),
      .fresh_seen   (fresh_seen),
      .drops_seen   (drops_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The one long hold-off lets the block fill up and back-pressure its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_arm && !hold_used) begin
         hold_used  <= 1'b1;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 18);
      end
   end

   task automatic send_word(input logic has, input int x, input int y, input logic last);
      int gap;
      gap = 0;
      if (!calm) begin
         while ($urandom_range(99) < 18) gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-X_W-Y_W){1'b0}}, Y_W'(y), X_W'(x)};
      req_tuser  <= has;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (has || last) words_sent++;
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_match_distance(input logic [MD_W-1:0] v);
      csr_wdata <= v;
      csr_wen   <= 1'b1;
      @(posedge clock);
      csr_wen   <= 1'b0;
      settings_used++;
   endtask

   task automatic pick_point(output int x, output int y);
      int mode;
      int k;
      mode = $urandom_range(99);
      if (seen_x.size() == 0 || mode >= 60) begin
         x = $urandom_range(639);
         y = $urandom_range(479);
      end else begin
         k = $urandom_range(seen_x.size() - 1);
         x = seen_x[k];
         y = seen_y[k];
         if (mode >= 15) begin
            x = x + int'($urandom_range(80)) - 40;
            y = y + int'($urandom_range(80)) - 40;
         end
      end
      if (x < 0) x = 0;
      if (x > 639) x = 639;
      if (y < 0) y = 0;
      if (y > 479) y = 479;
   endtask

   task automatic send_random_frame();
      int   n;
      int   roll;
      int   x;
      int   y;
      logic blob_ends;
      int   next_x[$];
      int   next_y[$];
      roll = $urandom_range(99);
      if (roll < 3) n = $urandom_range(FRAME_CAP + 1, FRAME_CAP + 4);
      else if (roll < 11) n = 0;
      else n = $urandom_range(1, 6);
      blob_ends = (n > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 5) send_word(1'b0, $urandom_range(639), $urandom_range(479), 1'b0);
         if ($urandom_range(99) < 2) drain_all();
         pick_point(x, y);
         next_x = {next_x, x};
         next_y = {next_y, y};
         send_word(1'b1, x, y, blob_ends && (i == n - 1));
      end
      if (!blob_ends) send_word(1'b0, $urandom_range(639), $urandom_range(479), 1'b1);
      seen_x = next_x;
      seen_y = next_y;
   endtask

   initial begin
      logic [MD_W-1:0] md_plan[5];
      int              goal;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first frame sees no earlier blobs; the second probes the match boundary,
      // equal distances and the image corners.
      send_word(1'b1, 0, 0, 1'b0);
      send_word(1'b1, 639, 479, 1'b0);
      send_word(1'b1, 200, 200, 1'b0);
      send_word(1'b1, 200, 200, 1'b0);
      send_word(1'b1, 300, 300, 1'b0);
      send_word(1'b1, 310, 300, 1'b1);
      send_word(1'b0, 511, 256, 1'b0);
      send_word(1'b1, 30, 0, 1'b0);
      send_word(1'b1, 639, 448, 1'b0);
      send_word(1'b1, 200, 200, 1'b0);
      send_word(1'b1, 305, 300, 1'b0);
      send_word(1'b1, 0, 479, 1'b0);
      send_word(1'b0, 0, 0, 1'b1);
      send_word(1'b0, 639, 479, 1'b1);
      send_word(1'b1, 5, 5, 1'b0);
      send_word(1'b0, 5, 5, 1'b1);
      drain_all();

      md_plan[0] = '0;
      md_plan[1] = '1;
      md_plan[2] = MD_W'($urandom_range(1, 100));
      md_plan[3] = MD_W'($urandom_range(101, 1022));
      md_plan[4] = MD_RESET;
      for (int p = 0; p < 5; p++) begin
         write_match_distance(md_plan[p]);
         if (p == 1) long_hold_arm <= 1'b1;
         goal = words_sent + 200;
         while (words_sent < goal) send_random_frame();
         drain_all();
      end

      // An empty previous frame makes every blob cheap, so one long frame without idle
      // cycles overflows the bank and the extra blobs are dropped.
      send_word(1'b0, 0, 0, 1'b1);
      send_word(1'b0, 0, 0, 1'b1);
      calm <= 1'b1;
      for (int i = 0; i < 150; i++) begin
         send_word(1'b1, $urandom_range(639), $urandom_range(479), i == 149);
      end
      calm <= 1'b0;
      seen_x.delete();
      seen_y.delete();
      send_random_frame();
      drain_all();
      repeat (50) @(posedge clock);

      $display("Sent %0d words under %0d match distance settings, checked %0d results",
               words_sent, settings_used, results_seen);
      $display("(%0d fresh IDs, %0d dropped blobs).", fresh_seen, drops_seen);
      if (fail_count == 0 && backlog == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, backlog);
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("Run timed out.");
      $display("== FAIL ==");
      $finish;
   end

endmodule
